// ===== rtl/jsif_pkg.sv =====
package jsif_pkg;

    localparam logic [2:0] CLS_BETWEEN = 3'd0;
    localparam logic [2:0] CLS_MESSAGE = 3'd1;
    localparam logic [2:0] CLS_DATA    = 3'd2;
    localparam logic [2:0] CLS_SPACE   = 3'd3;
    localparam logic [2:0] CLS_RESET   = 3'd4;
    localparam logic [2:0] CLS_ERROR   = 3'd5;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_LSQUARE = 8'h5B;
    localparam logic [7:0] CH_RSQUARE = 8'h5D;
    localparam logic [7:0] CH_LCURLY  = 8'h7B;
    localparam logic [7:0] CH_RCURLY  = 8'h7D;

    typedef struct packed {
        logic       inside_string;
        logic       escape_pending;
        logic [2:0] item_kind;
    } scan_flags_t;

    typedef struct packed {
        logic [2:0] byte_class;
        logic       item_start;
        logic       item_end;
        logic       format_error;
        logic       reset_notice;
    } tag_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

endpackage

// ===== rtl/jsif_step.sv =====
module jsif_step
    import jsif_pkg::*;
#(
    parameter int MAX_DEPTH = 255,
    parameter int DEPTH_W   = 8
)
(
    input  logic [7:0]         data_byte,
    input  logic [DEPTH_W-1:0] depth,
    input  scan_flags_t        flags,
    output logic [DEPTH_W-1:0] depth_next,
    output scan_flags_t        flags_next,
    output tag_t               tag
);

    localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = DEPTH_W'(MAX_DEPTH);
    localparam logic [DEPTH_W-1:0] DEPTH_ZERO  = '0;
    localparam logic [DEPTH_W-1:0] DEPTH_ONE   = DEPTH_W'(1);

    logic at_top;
    logic err;

    assign at_top = (depth == DEPTH_ZERO);

    always_comb
    begin
        depth_next = depth;
        flags_next = flags;
        tag        = '0;
        err        = 1'b0;
        tag.byte_class = flags.item_kind;

        if (data_byte == CH_NUL)
        begin
            tag.reset_notice = (flags.item_kind != CLS_RESET);
            depth_next = DEPTH_ZERO;
            flags_next.inside_string  = 1'b0;
            flags_next.escape_pending = 1'b0;
            flags_next.item_kind      = CLS_RESET;
            tag.byte_class = CLS_RESET;
        end
        else if (flags.item_kind == CLS_ERROR)
        begin
            tag.byte_class = CLS_ERROR;
        end
        else if (!at_top && !flags.inside_string && is_ws(data_byte))
        begin
            tag.byte_class = CLS_SPACE;
        end
        else if (flags.inside_string)
        begin
            if (flags.escape_pending)
                flags_next.escape_pending = 1'b0;
            else if (data_byte == CH_QUOTE)
                flags_next.inside_string = 1'b0;
            else if (data_byte == CH_BSLASH)
                flags_next.escape_pending = 1'b1;
        end
        else if (data_byte == CH_LSQUARE || data_byte == CH_LCURLY)
        begin
            if (depth == DEPTH_LIMIT)
            begin
                err = 1'b1;
            end
            else
            begin
                if (at_top)
                begin
                    flags_next.item_kind = (data_byte == CH_LSQUARE) ? CLS_MESSAGE : CLS_DATA;
                    tag.item_start = 1'b1;
                end
                depth_next = depth + DEPTH_ONE;
                tag.byte_class = flags_next.item_kind;
            end
        end
        else if (data_byte == CH_RSQUARE || data_byte == CH_RCURLY)
        begin
            if (at_top)
            begin
                err = 1'b1;
            end
            else
            begin
                depth_next = depth - DEPTH_ONE;
                if (depth == DEPTH_ONE)
                begin
                    tag.item_end = 1'b1;
                    flags_next.item_kind = CLS_BETWEEN;
                end
            end
        end
        else if (data_byte == CH_QUOTE)
        begin
            if (!at_top)
                flags_next.inside_string = 1'b1;
            else
                err = 1'b1;
        end
        else if (at_top)
        begin
            if (is_ws(data_byte))
                tag.byte_class = CLS_BETWEEN;
            else
                err = 1'b1;
        end

        if (err)
        begin
            flags_next.item_kind = CLS_ERROR;
            tag.byte_class       = CLS_ERROR;
            tag.format_error     = 1'b1;
        end
    end

endmodule

// ===== rtl/json_stream_item_framer_core.sv =====
// Tags each byte of a JSON stream against top-level items: one byte is taken
// per cycle unless result_stall holds the output; its tag passes the byte
// register, then the result register. Throughput is one byte per cycle when
// not stalled; it is bounded by the update of the bracket depth and string
// flags, which every byte needs before the next. A zero byte clears all
// framing state; after a format error every byte is tagged discarded until
// a zero byte. MAX_DEPTH sets the deepest bracket nesting accepted.
module json_stream_item_framer_core
    import jsif_pkg::*;
#(
    parameter int MAX_DEPTH = 255
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] data_byte,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [2:0] byte_class,
    output logic       item_start,
    output logic       item_end,
    output logic       format_error,
    output logic       reset_notice
);

    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

    logic               hold_valid_reg;
    logic               hold_valid_next;
    logic [7:0]         hold_byte_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;
    scan_flags_t        flags_reg;
    scan_flags_t        flags_next;
    tag_t               tag_next;
    tag_t               tag_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               advance;
    logic               accept;

    assign advance    = hold_valid_reg && (!out_valid_reg || !result_stall);
    assign byte_stall = hold_valid_reg && !advance;
    assign accept     = byte_valid && !byte_stall;

    assign hold_valid_next = accept || (hold_valid_reg && !advance);
    assign out_valid_next  = advance || (out_valid_reg && result_stall);

    jsif_step #(
        .MAX_DEPTH (MAX_DEPTH),
        .DEPTH_W   (DEPTH_W)
    ) u_step (
        .data_byte  (hold_byte_reg),
        .depth      (depth_reg),
        .flags      (flags_reg),
        .depth_next (depth_next),
        .flags_next (flags_next),
        .tag        (tag_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            depth_reg      <= '0;
            flags_reg      <= '{inside_string: 1'b0, escape_pending: 1'b0,
                                item_kind: CLS_BETWEEN};
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            if (advance)
            begin
                depth_reg <= depth_next;
                flags_reg <= flags_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            hold_byte_reg <= data_byte;
        if (advance)
            tag_reg <= tag_next;
    end

    assign result_valid = out_valid_reg;
    assign byte_class   = tag_reg.byte_class;
    assign item_start   = tag_reg.item_start;
    assign item_end     = tag_reg.item_end;
    assign format_error = tag_reg.format_error;
    assign reset_notice = tag_reg.reset_notice;

endmodule
